// ===== rtl/timed_action_queue_sequencer_top_assert.svh =====
// assertion macros used by the checker file
`ifndef TIMED_ACTION_QUEUE_SEQUENCER_TOP_ASSERT_SVH
`define TIMED_ACTION_QUEUE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define TAQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// next-cycle implication
`define TAQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ===== rtl/taqs_pkg.sv =====
`default_nettype none

package taqs_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_POLL       = 3'd1,
        CMD_TICK       = 3'd2,
        CMD_FULL_STOP  = 3'd3,
        CMD_QUIET_STOP = 3'd4,
        CMD_INIT       = 3'd5
    } t_cmd;

    // action kinds
    localparam logic [2:0] KIND_BREATH = 3'd0;
    localparam logic [2:0] KIND_DELAY  = 3'd1;
    localparam logic [2:0] KIND_PLAY   = 3'd2;
    localparam logic [2:0] KIND_PWRON  = 3'd3;
    localparam logic [2:0] KIND_PWROFF = 3'd4;

    // one-hot running flags
    localparam logic [4:0] FLAG_IDLE   = 5'b00000;
    localparam logic [4:0] FLAG_BREATH = 5'b10000;
    localparam logic [4:0] FLAG_DELAY  = 5'b01000;
    localparam logic [4:0] FLAG_PLAY   = 5'b00100;
    localparam logic [4:0] FLAG_PWRON  = 5'b00010;
    localparam logic [4:0] FLAG_PWROFF = 5'b00001;

    localparam logic [15:0] FINAL_DELAY_RST = 16'd10;

    // one queue slot
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] duration;
        logic [7:0]  param;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic push_write;
        logic start_pop;
        logic arm_final;
        logic timer_dec;
        logic disarm;
        logic clear_queue;
        logic clear_flag;
        logic stop_play;
        logic power_off;
        logic seq_done;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic queue_full;
        logic queue_empty;
        logic flag_idle;
        logic playing;
        logic timer_armed;
        logic timer_expiring;
        logic timer_final;
    } t_dp_status;

    function automatic logic [4:0] flag_of_kind(input logic [2:0] kind);
        logic [4:0] flag;
        case (kind)
            KIND_BREATH: flag = FLAG_BREATH;
            KIND_DELAY:  flag = FLAG_DELAY;
            KIND_PLAY:   flag = FLAG_PLAY;
            KIND_PWRON:  flag = FLAG_PWRON;
            KIND_PWROFF: flag = FLAG_PWROFF;
            default:     flag = FLAG_IDLE;
        endcase
        return flag;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/timed_action_queue_sequencer_top.sv =====
// channel  | ports                                           | handshake
// ---------+-------------------------------------------------+-------------------------
// input    | i_cmd i_action_kind i_duration i_action_param   | start high, busy low
// result   | o_accepted o_started o_started_kind ...         | o_res_valid, one cycle
//          | o_started_param o_stop_playback o_power_off     |
//          | o_sequence_done o_busy_res                      |
// config   | i_cfg_wdata (final_delay)                       | i_cfg_we, no wait
//
// every word passes through capture, then the execute state behind the registered
// read of the head slot in the queue memory; no new word is taken while busy is high
// the result shows in the cycle after the execute state, as the next word can be captured
// synchronous active-low reset empties the queue, idles the timer, final_delay = 10
// the receiver cannot stall: each result is flagged by o_res_valid for exactly one cycle
`default_nettype none

module timed_action_queue_sequencer_top
    import taqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [2:0]  i_action_kind,
    input  wire logic [15:0] i_duration,
    input  wire logic [7:0]  i_action_param,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output logic             o_res_valid,
    output logic             o_accepted,
    output logic             o_started,
    output logic [2:0]       o_started_kind,
    output logic [7:0]       o_started_param,
    output logic             o_stop_playback,
    output logic             o_power_off,
    output logic             o_sequence_done,
    output logic             o_busy_res
);

    t_ctl_cmd   ctl;
    t_dp_status status;

    // sequencing and decisions
    taqs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // queue, timer and result registers
    taqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_action_kind   (i_action_kind),
        .i_duration      (i_duration),
        .i_action_param  (i_action_param),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_status        (status),
        .o_res_valid     (o_res_valid),
        .o_accepted      (o_accepted),
        .o_started       (o_started),
        .o_started_kind  (o_started_kind),
        .o_started_param (o_started_param),
        .o_stop_playback (o_stop_playback),
        .o_power_off     (o_power_off),
        .o_sequence_done (o_sequence_done),
        .o_busy_res      (o_busy_res)
    );

endmodule

`default_nettype wire

// ===== rtl/taqs_ctrl.sv =====
`default_nettype none

module taqs_ctrl
    import taqs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [2:0] i_cmd,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_ctl,
    output logic            o_busy
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic       r_busy;
    logic       n_busy;
    logic [2:0] r_cmd;
    logic       capture;
    logic       exec;
    logic       expire;

    assign capture = start && !r_busy;
    assign exec    = (r_state == S_EXEC);
    assign o_busy  = r_busy;

    // next state
    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                    n_busy  = 1'b1;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    // command word held for the execute cycle
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_cmd <= i_cmd;
        end
    end

    // decisions for the execute cycle
    always_comb begin
        o_ctl         = '0;
        o_ctl.capture = capture;
        o_ctl.exec    = exec;
        expire        = i_status.timer_armed && i_status.timer_expiring;
        if (exec) begin
            case (r_cmd)
                CMD_PUSH: begin
                    o_ctl.push_write = !i_status.queue_full;
                end
                CMD_POLL: begin
                    o_ctl.start_pop = i_status.flag_idle && !i_status.queue_empty;
                end
                CMD_TICK: begin
                    o_ctl.timer_dec = i_status.timer_armed && !i_status.timer_expiring;
                    o_ctl.disarm    = expire;
                    o_ctl.seq_done  = expire && i_status.timer_final;
                    if (expire && !i_status.timer_final) begin
                        o_ctl.stop_play = i_status.playing;
                        o_ctl.start_pop = !i_status.queue_empty;
                        o_ctl.arm_final = i_status.queue_empty && !i_status.flag_idle;
                    end
                end
                CMD_FULL_STOP: begin
                    o_ctl.disarm      = 1'b1;
                    o_ctl.clear_queue = 1'b1;
                    o_ctl.clear_flag  = 1'b1;
                    o_ctl.stop_play   = i_status.playing;
                    o_ctl.power_off   = 1'b1;
                end
                CMD_QUIET_STOP: begin
                    o_ctl.disarm      = 1'b1;
                    o_ctl.clear_queue = 1'b1;
                    o_ctl.clear_flag  = 1'b1;
                end
                CMD_INIT: begin
                    o_ctl.disarm      = 1'b1;
                    o_ctl.clear_queue = 1'b1;
                    o_ctl.stop_play   = i_status.playing;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/taqs_datapath.sv =====
`default_nettype none

module taqs_datapath
    import taqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl_cmd    i_ctl,
    input  wire logic [2:0]  i_action_kind,
    input  wire logic [15:0] i_duration,
    input  wire logic [7:0]  i_action_param,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output t_dp_status       o_status,
    output logic             o_res_valid,
    output logic             o_accepted,
    output logic             o_started,
    output logic [2:0]       o_started_kind,
    output logic [7:0]       o_started_param,
    output logic             o_stop_playback,
    output logic             o_power_off,
    output logic             o_sequence_done,
    output logic             o_busy_res
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

    // slot memory, no reset
    t_slot r_mem [QUEUE_DEPTH];
    t_slot r_rd_slot;
    t_slot r_in_slot;

    logic [PW-1:0] r_read_ptr;
    logic [PW-1:0] n_read_ptr;
    logic [PW-1:0] r_write_ptr;
    logic [PW-1:0] n_write_ptr;
    logic [PW-1:0] rd_inc;
    logic [PW-1:0] wr_inc;
    logic [4:0]    r_flag;
    logic [4:0]    n_flag;
    logic [15:0]   r_count;
    logic [15:0]   n_count;
    logic          r_armed;
    logic          n_armed;
    logic          r_final;
    logic          n_final;
    logic [15:0]   r_final_delay;
    logic          r_res_valid;

    // ring pointer increments
    assign rd_inc = (r_read_ptr == LAST_IDX) ? '0 : r_read_ptr + 1'b1;
    assign wr_inc = (r_write_ptr == LAST_IDX) ? '0 : r_write_ptr + 1'b1;

    // status for the controller
    assign o_status.queue_full     = (wr_inc == r_read_ptr);
    assign o_status.queue_empty    = (r_read_ptr == r_write_ptr);
    assign o_status.flag_idle      = (r_flag == FLAG_IDLE);
    assign o_status.playing        = (r_flag == FLAG_PLAY);
    assign o_status.timer_armed    = r_armed;
    assign o_status.timer_expiring = (r_count <= 16'd1);
    assign o_status.timer_final    = r_final;

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_in_slot <= '{kind: i_action_kind, duration: i_duration, param: i_action_param};
        end
    end

    // memory write and registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push_write) begin
            r_mem[r_write_ptr] <= r_in_slot;
        end
        r_rd_slot <= r_mem[r_read_ptr];
    end

    // next pointers, timer and flag
    always_comb begin
        n_read_ptr  = r_read_ptr;
        n_write_ptr = r_write_ptr;
        n_flag      = r_flag;
        n_count     = r_count;
        n_armed     = r_armed;
        n_final     = r_final;
        if (i_ctl.clear_queue) begin
            n_read_ptr  = '0;
            n_write_ptr = '0;
        end
        if (i_ctl.push_write) begin
            n_write_ptr = wr_inc;
        end
        if (i_ctl.clear_flag) begin
            n_flag = FLAG_IDLE;
        end
        if (i_ctl.disarm) begin
            n_count = '0;
            n_armed = 1'b0;
            n_final = 1'b0;
        end
        if (i_ctl.timer_dec) begin
            n_count = r_count - 16'd1;
        end
        if (i_ctl.start_pop) begin
            n_read_ptr = rd_inc;
            n_flag     = flag_of_kind(r_rd_slot.kind);
            n_count    = r_rd_slot.duration;
            n_armed    = 1'b1;
            n_final    = 1'b0;
        end
        if (i_ctl.arm_final) begin
            n_flag  = FLAG_IDLE;
            n_count = r_final_delay;
            n_armed = 1'b1;
            n_final = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_ptr    <= '0;
            r_write_ptr   <= '0;
            r_flag        <= FLAG_IDLE;
            r_count       <= '0;
            r_armed       <= 1'b0;
            r_final       <= 1'b0;
            r_final_delay <= FINAL_DELAY_RST;
            r_res_valid   <= 1'b0;
        end else begin
            r_read_ptr  <= n_read_ptr;
            r_write_ptr <= n_write_ptr;
            r_flag      <= n_flag;
            r_count     <= n_count;
            r_armed     <= n_armed;
            r_final     <= n_final;
            r_res_valid <= i_ctl.exec;
            if (i_cfg_we) begin
                r_final_delay <= i_cfg_wdata;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            o_accepted      <= i_ctl.push_write;
            o_started       <= i_ctl.start_pop;
            o_started_kind  <= i_ctl.start_pop ? r_rd_slot.kind : 3'd0;
            o_started_param <= i_ctl.start_pop ? r_rd_slot.param : 8'd0;
            o_stop_playback <= i_ctl.stop_play;
            o_power_off     <= i_ctl.power_off;
            o_sequence_done <= i_ctl.seq_done;
            o_busy_res      <= (n_flag != FLAG_IDLE);
        end
    end

    assign o_res_valid = r_res_valid;

endmodule

`default_nettype wire

// ===== rtl/taqs_checker.sv =====
`default_nettype none
`include "timed_action_queue_sequencer_top_assert.svh"

module taqs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_res_valid,
    input wire logic       o_accepted,
    input wire logic       o_started,
    input wire logic [2:0] o_started_kind,
    input wire logic [7:0] o_started_param,
    input wire logic       o_sequence_done,
    input wire logic       o_busy_res
);

    // each accepted word sets busy, and its result shows as busy falls
    `TAQS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy)
    `TAQS_ASSERT_NEXT(a_result_after_exec, i_clk, i_rst_n, busy, o_res_valid && !busy)

    // a push result never also starts an action or reports done
    `TAQS_ASSERT_SAME(a_push_exclusive, i_clk, i_rst_n, o_res_valid && o_accepted,
        !o_started && !o_sequence_done && !o_busy_res || !o_started && !o_sequence_done)

    // no start means the start fields stay zero
    `TAQS_ASSERT_SAME(a_idle_start_fields, i_clk, i_rst_n, o_res_valid && !o_started,
        o_started_kind == 3'd0 && o_started_param == 8'd0)

endmodule

bind timed_action_queue_sequencer_top taqs_checker u_taqs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_res_valid     (o_res_valid),
    .o_accepted      (o_accepted),
    .o_started       (o_started),
    .o_started_kind  (o_started_kind),
    .o_started_param (o_started_param),
    .o_sequence_done (o_sequence_done),
    .o_busy_res      (o_busy_res)
);

`default_nettype wire

// ===== verif/timed_action_queue_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module timed_action_queue_sequencer_top_tb;
    import taqs_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int RST_CYCLES  = 5;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 6;
    localparam int PHASE_WORDS = 280;

    // codes with no name in the package
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] KIND_ODD_5  = 3'd5;
    localparam logic [2:0] KIND_ODD_7  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  kind;
        logic [15:0] duration;
        logic [7:0]  param;
    } t_action_word;

    typedef struct packed {
        logic       accepted;
        logic       started;
        logic [2:0] kind;
        logic [7:0] param;
        logic       stop_playback;
        logic       power_off;
        logic       sequence_done;
        logic       busy;
    } t_action_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [2:0]  i_action_kind;
    logic [15:0] i_duration;
    logic [7:0]  i_action_param;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        o_res_valid;
    logic        o_accepted;
    logic        o_started;
    logic [2:0]  o_started_kind;
    logic [7:0]  o_started_param;
    logic        o_stop_playback;
    logic        o_power_off;
    logic        o_sequence_done;
    logic        o_busy_res;

    timed_action_queue_sequencer_top #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_action_kind  (i_action_kind),
        .i_duration     (i_duration),
        .i_action_param (i_action_param),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_res_valid    (o_res_valid),
        .o_accepted     (o_accepted),
        .o_started      (o_started),
        .o_started_kind (o_started_kind),
        .o_started_param(o_started_param),
        .o_stop_playback(o_stop_playback),
        .o_power_off    (o_power_off),
        .o_sequence_done(o_sequence_done),
        .o_busy_res     (o_busy_res)
    );

    always #4 i_clk = ~i_clk;

    // words waiting to be driven, and answers waiting to come back
    t_action_word   word_q[$];
    t_action_result answer_q[$];

    int words_sent      = 0;
    int words_taken_cnt = 0;
    int mismatch_cnt    = 0;
    int stall_cycles    = 0;
    int gap_left        = 0;
    bit burst_run       = 1'b0;
    bit word_taken      = 1'b0;
    t_action_word drv_word;

    // shadow copy of the sequencer state
    t_slot       slot_mem [QDEPTH];
    int          head_idx  = 0;
    int          tail_idx  = 0;
    logic [4:0]  run_flag  = FLAG_IDLE;
    logic [15:0] tmr_count = '0;
    logic        tmr_armed = 1'b0;
    logic        tmr_final = 1'b0;
    logic [15:0] final_delay_cfg = FINAL_DELAY_RST;

    function automatic void disarm_timer();
        tmr_armed = 1'b0;
        tmr_final = 1'b0;
        tmr_count = '0;
    endfunction

    // take the head action and run it; 0 when the queue is empty
    function automatic logic pop_head(inout t_action_result r);
        t_slot s;
        if (head_idx == tail_idx)
            return 1'b0;
        s = slot_mem[head_idx];
        head_idx = (head_idx + 1) % QDEPTH;
        case (s.kind)
            KIND_BREATH: run_flag = FLAG_BREATH;
            KIND_DELAY:  run_flag = FLAG_DELAY;
            KIND_PLAY:   run_flag = FLAG_PLAY;
            KIND_PWRON:  run_flag = FLAG_PWRON;
            KIND_PWROFF: run_flag = FLAG_PWROFF;
            default:     run_flag = FLAG_IDLE;
        endcase
        tmr_count = s.duration;
        tmr_armed = 1'b1;
        tmr_final = 1'b0;
        r.started = 1'b1;
        r.kind    = s.kind;
        r.param   = s.param;
        return 1'b1;
    endfunction

    // advance the shadow state by one word and give its answer
    function automatic t_action_result sequence_step(input t_action_word w);
        t_action_result r;
        logic was_final;
        r = '0;
        case (w.cmd)
            CMD_PUSH: begin
                if ((tail_idx + 1) % QDEPTH != head_idx) begin
                    slot_mem[tail_idx] = '{kind: w.kind, duration: w.duration, param: w.param};
                    tail_idx = (tail_idx + 1) % QDEPTH;
                    r.accepted = 1'b1;
                end
            end
            CMD_POLL: begin
                if (run_flag == FLAG_IDLE)
                    void'(pop_head(r));
            end
            CMD_TICK: begin
                if (tmr_armed) begin
                    if (tmr_count > 16'd1) begin
                        tmr_count = tmr_count - 16'd1;
                    end else begin
                        was_final = tmr_final;
                        disarm_timer();
                        if (was_final) begin
                            r.sequence_done = 1'b1;
                        end else begin
                            if (run_flag == FLAG_PLAY)
                                r.stop_playback = 1'b1;
                            if (!pop_head(r) && run_flag != FLAG_IDLE) begin
                                // queue ran dry: arm the final delay
                                run_flag  = FLAG_IDLE;
                                tmr_count = final_delay_cfg;
                                tmr_armed = 1'b1;
                                tmr_final = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_FULL_STOP: begin
                disarm_timer();
                if (run_flag == FLAG_PLAY)
                    r.stop_playback = 1'b1;
                head_idx    = 0;
                tail_idx    = 0;
                run_flag    = FLAG_IDLE;
                r.power_off = 1'b1;
            end
            CMD_QUIET_STOP: begin
                disarm_timer();
                head_idx = 0;
                tail_idx = 0;
                run_flag = FLAG_IDLE;
            end
            CMD_INIT: begin
                // running flag survives init
                head_idx = 0;
                tail_idx = 0;
                disarm_timer();
                if (run_flag == FLAG_PLAY)
                    r.stop_playback = 1'b1;
            end
            default: ;
        endcase
        r.busy = (run_flag != FLAG_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // driver: next word at the falling edge once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (word_q.size() > 0) begin
                drv_word = word_q.pop_front();
                i_cmd          <= drv_word.cmd;
                i_action_kind  <= drv_word.kind;
                i_duration     <= drv_word.duration;
                i_action_param <= drv_word.param;
                start          <= 1'b1;
                // gap ahead of the following word
                if ($urandom_range(0, 39) == 0)
                    burst_run = !burst_run;
                if (burst_run)
                    gap_left = 0;
                else if ($urandom_range(0, 99) < 55)
                    gap_left = 0;
                else if ($urandom_range(0, 99) < 85)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(5, 40);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on acceptance, check each result word, watchdog
    always @(posedge i_clk) begin
        t_action_result want;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                word_taken = 1'b1;
                answer_q.push_back(sequence_step(drv_word));
                words_taken_cnt++;
            end
            if (o_res_valid) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = answer_q.pop_front();
                    check_field("accepted", 16'(o_accepted), 16'(want.accepted));
                    check_field("started", 16'(o_started), 16'(want.started));
                    check_field("started_kind", 16'(o_started_kind), 16'(want.kind));
                    check_field("started_param", 16'(o_started_param), 16'(want.param));
                    check_field("stop_playback", 16'(o_stop_playback),
                                16'(want.stop_playback));
                    check_field("power_off", 16'(o_power_off), 16'(want.power_off));
                    check_field("sequence_done", 16'(o_sequence_done),
                                16'(want.sequence_done));
                    check_field("busy_res", 16'(o_busy_res), 16'(want.busy));
                end
            end
            if (word_taken || o_res_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: %0d words pending", answer_q.size() + word_q.size());
                $display("timed_action_queue_sequencer_top_tb: errors");
                $finish;
            end
        end
    end

    task automatic add_word(input logic [2:0] cmd, input logic [2:0] kind,
                            input logic [15:0] dur, input logic [7:0] par);
        word_q.push_back('{cmd: cmd, kind: kind, duration: dur, param: par});
        words_sent++;
    endtask

    // control word with junk in the unused fields
    task automatic add_cmd(input logic [2:0] cmd);
        add_word(cmd, 3'($urandom_range(0, 7)), 16'($urandom()),
                 8'($urandom_range(0, 255)));
    endtask

    // mostly short durations, now and then huge ones
    function automatic logic [15:0] rand_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 16'($urandom_range(0, 3));
        else if (r < 95)
            return 16'($urandom_range(4, 12));
        else if (r < 97)
            return 16'hFFFF;
        else
            return 16'($urandom());
    endfunction

    function automatic logic [2:0] rand_kind();
        if ($urandom_range(0, 9) < 8)
            return 3'($urandom_range(KIND_BREATH, KIND_PWROFF));
        return 3'($urandom_range(KIND_ODD_5, KIND_ODD_7));
    endfunction

    // wait until every word is answered, then let the pipeline empty
    task automatic settle();
        while (!(word_q.size() == 0 && words_taken_cnt == words_sent
                 && answer_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_final_delay(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        final_delay_cfg = value;
    endtask

    initial begin
        logic [15:0] delay_plan [7];
        logic [15:0] dur;
        int          n_push;
        int          tick_need;
        int          phase_words;
        int          mark;
        int          r;

        delay_plan = '{16'd3, 16'hFFFF, 16'd0, 16'd2, 16'd10, 16'd1, 16'd6};
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = CMD_PUSH;
        i_action_kind  = '0;
        i_duration     = '0;
        i_action_param = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short final delay so done shows quickly
        write_final_delay(16'd1);
        add_word(CMD_PUSH, KIND_PLAY, 16'd1, 8'hFF);
        add_word(CMD_PUSH, KIND_ODD_7, 16'd0, 8'hA5);
        add_word(CMD_PUSH, KIND_DELAY, 16'hFFFF, 8'h00);
        add_cmd(CMD_POLL);
        // poll while running is ignored
        add_cmd(CMD_POLL);
        // play ends: stop playback, unknown kind starts with idle flag
        add_cmd(CMD_TICK);
        add_cmd(CMD_POLL);
        add_cmd(CMD_TICK);
        add_cmd(CMD_SPARE_6);
        add_cmd(CMD_SPARE_7);
        // init keeps the delay flag and blocks polls
        add_cmd(CMD_INIT);
        add_cmd(CMD_POLL);
        add_cmd(CMD_QUIET_STOP);
        add_word(CMD_PUSH, KIND_PWRON, 16'd2, 8'h01);
        add_cmd(CMD_POLL);
        add_cmd(CMD_TICK);
        add_cmd(CMD_TICK);
        // new action replaces a pending final timer
        add_word(CMD_PUSH, KIND_PWROFF, 16'd0, 8'h80);
        add_cmd(CMD_POLL);
        add_cmd(CMD_TICK);
        add_cmd(CMD_TICK);
        add_word(CMD_PUSH, KIND_PLAY, 16'd3, 8'h5A);
        add_cmd(CMD_POLL);
        add_cmd(CMD_FULL_STOP);
        add_cmd(CMD_FULL_STOP);
        settle();

        // random phases, one final delay setting each
        foreach (delay_plan[ph]) begin
            write_final_delay(delay_plan[ph]);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                mark = words_sent;
                if ($urandom_range(0, 6) == 0) begin
                    // noise burst, unused commands included
                    repeat ($urandom_range(1, 6))
                        add_cmd(3'($urandom_range(CMD_PUSH, CMD_SPARE_7)));
                end else begin
                    // load a script, start it and tick it through, or part way when the ticks are capped
                    if ($urandom_range(0, 9) == 0)
                        n_push = $urandom_range(QDEPTH - 2, QDEPTH + 1);
                    else
                        n_push = $urandom_range(1, 4);
                    tick_need = (final_delay_cfg == 16'd0) ? 2 : int'(final_delay_cfg) + 1;
                    repeat (n_push) begin
                        dur = rand_duration();
                        add_word(CMD_PUSH, rand_kind(), dur, 8'($urandom_range(0, 255)));
                        tick_need += (dur == 16'd0) ? 1 : int'(dur);
                    end
                    add_cmd(CMD_POLL);
                    if (tick_need > 60)
                        tick_need = $urandom_range(5, 60);
                    repeat (tick_need) begin
                        r = $urandom_range(0, 39);
                        if (r == 0)
                            add_cmd(CMD_POLL);
                        else if (r == 1)
                            add_word(CMD_PUSH, rand_kind(), rand_duration(),
                                     8'($urandom_range(0, 255)));
                        add_cmd(CMD_TICK);
                    end
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        add_cmd(CMD_FULL_STOP);
                    end else if (r == 1) begin
                        add_cmd(CMD_QUIET_STOP);
                    end else if (r == 2) begin
                        add_cmd(CMD_INIT);
                        if ($urandom_range(0, 9) < 7)
                            add_cmd($urandom_range(0, 1) ? CMD_FULL_STOP : CMD_QUIET_STOP);
                    end
                end
                phase_words += words_sent - mark;
            end
            settle();
        end

        if (answer_q.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
        if (mismatch_cnt == 0)
            $display("timed_action_queue_sequencer_top_tb: clean");
        else
            $display("timed_action_queue_sequencer_top_tb: errors");
        $finish;
    end

endmodule
